[src/particle_pool_update_assert.svh]
// Assertion macros for the particle pool update block.
// Used by the checker module; depends on i_clk and i_rst_n being in scope.
`ifndef PARTICLE_POOL_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define PPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define PPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ppu_pkg.sv]
// Shared types and constants of the particle pool update block.
// No dependencies; imported by every module of the block but ppu_ram.
package ppu_pkg;

    // Pool geometry.
    localparam int PPU_DEPTH = 1024;
    localparam int PPU_AW    = $clog2(PPU_DEPTH);
    localparam int PPU_CW    = $clog2(PPU_DEPTH + 1);
    localparam logic [PPU_AW:0]   PPU_FULL = (PPU_AW + 1)'(PPU_DEPTH);
    localparam logic [PPU_AW-1:0] PPU_LAST = PPU_AW'(PPU_DEPTH - 1);

    // Stream widths.
    localparam int PPU_IN_W   = 360;
    localparam int PPU_OUT_W  = 208;
    localparam int PPU_OP_W   = 2;

    // Item kinds.
    localparam logic [1:0] OP_EMIT_RAD = 2'd0;
    localparam logic [1:0] OP_EMIT_DEG = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    // Blend factor of one in Q1.16, and the quotient bits the divider produces.
    localparam logic [16:0] PPU_Q_ONE  = 17'h10000;
    localparam int          PPU_QBITS  = 16;

    // Pi / 180 in Q0.32.
    localparam logic signed [31:0] PPU_DEG_K = 32'sd74961321;
    localparam logic signed [64:0] PPU_HALF32 = 65'sd2147483648;

    // Sequence of the shared multiplier during a tick.
    localparam logic [3:0] MS_VX    = 4'd0;
    localparam logic [3:0] MS_VY    = 4'd1;
    localparam logic [3:0] MS_ROT   = 4'd2;
    localparam logic [3:0] MS_SCALE = 4'd3;
    localparam logic [3:0] MS_COL0  = 4'd4;
    localparam logic [3:0] MS_COL3  = 4'd7;
    localparam logic [3:0] MS_DONE  = 4'd8;

    // Input item payload, first field in the highest bits.
    typedef struct packed {
        logic [9:0]  slot;
        logic [30:0] delta_time;
        logic [30:0] lifetime;
        logic [63:0] rotation_pair;
        logic [31:0] scale_pair;
        logic [31:0] end_color;
        logic [31:0] start_color;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_in_data;

    // Result item payload.
    typedef struct packed {
        logic        pad;
        logic [9:0]  highest_used;
        logic [10:0] live_count;
        logic [31:0] out_remaining;
        logic [31:0] out_rotation;
        logic [15:0] out_scale;
        logic [31:0] out_color;
        logic [31:0] out_y;
        logic [31:0] out_x;
        logic [9:0]  slot_used;
    } t_out_data;

    // One particle slot as kept in the particle memory.
    typedef struct packed {
        logic [31:0] remaining;
        logic [31:0] total;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] color_a;
        logic [31:0] color_b;
        logic [31:0] scale_pair;
        logic [31:0] rot_a;
        logic [31:0] rot_b;
    } t_part;

    // Values shown for one slot, refreshed for each live slot by each tick.
    typedef struct packed {
        logic [31:0] color;
        logic [15:0] scale;
        logic [31:0] rot;
    } t_render;

    // Divider request and response.
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;

    // Operands of the shared multiplier.
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [31:0] b;
    } t_mul_req;

endpackage

[src/ppu_ram.sv]
// Generic simple dual-port synchronous RAM with registered read data.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[src/ppu_div.sv]
// Restoring divider giving the 16 fraction bits of num / den, for num < den.
// Depends on ppu_pkg.
module ppu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppu_pkg::t_div_req i_req,
    output ppu_pkg::t_div_rsp o_rsp
);
    import ppu_pkg::*;

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quo;
    logic        r_done;
    logic [32:0] c_trial;
    logic        c_ge;
    logic [32:0] c_diff;

    // One quotient bit a cycle: shift, compare and subtract.
    always_comb begin
        c_trial = {r_rem, 1'b0};
        c_ge    = c_trial >= {1'b0, r_den};
        c_diff  = c_ge ? (c_trial - {1'b0, r_den}) : c_trial;
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(PPU_QBITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= c_diff[31:0];
            r_quo <= {r_quo[14:0], c_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

[src/ppu_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on ppu_pkg.
module ppu_mul (
    input  logic               i_clk,
    input  ppu_pkg::t_mul_req  i_req,
    output logic signed [64:0] o_prod
);
    import ppu_pkg::*;

    // One product a cycle, available in the next cycle.
    always_ff @(posedge i_clk) begin
        o_prod <= i_req.a * i_req.b;
    end

endmodule

[src/particle_pool_update.sv]
// Particle pool update: top level with the slot sequencer and bookkeeping.
// Depends on ppu_pkg, ppu_ram, ppu_div and ppu_mul.
//
// Usage. Items enter on the s_axis channel: tuser carries the kind (emit in
// radians, emit in degrees, tick, read slot), tdata the spawn fields, the
// time step and the slot. Every item gives exactly one result on m_axis;
// tuser there is the accepted flag, tdata the slot and render fields, the
// live count and the highest slot in use.
// One item is worked on at a time; s_axis_tready is high only while idle.
// An emit searches upwards from the claimed slot for the next free slot, and
// in degrees first converts both rotation ends. A tick walks slots 0 up to
// the highest in use through the particle memory; each live slot takes a
// blend factor of one, or the divider works it out, and the shared
// multiplier then gives 8 products for it.
// After reset the particle and render memories are cleared, one slot a
// cycle, and no item is accepted meanwhile. Results wait in an output
// register; a stalled receiver holds the result there and the block, once
// finished with its next item, waits for it.
module particle_pool_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, start_color, end_color, scale_pair,
    // rotation_pair, lifetime, delta_time, slot
    input  logic [ppu_pkg::PPU_IN_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [ppu_pkg::PPU_OP_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // slot_used, out_x, out_y, out_color, out_scale, out_rotation,
    // out_remaining, live_count, highest_used
    output logic [ppu_pkg::PPU_OUT_W-1:0]  m_axis_tdata,
    // accepted
    output logic                           m_axis_tuser
);
    import ppu_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EDEG0 = 4'd2;
    localparam logic [3:0] S_EDEG1 = 4'd3;
    localparam logic [3:0] S_EDEG2 = 4'd4;
    localparam logic [3:0] S_EWR   = 4'd5;
    localparam logic [3:0] S_ESCAN = 4'd6;
    localparam logic [3:0] S_TLOAD = 4'd7;
    localparam logic [3:0] S_TDIV  = 4'd8;
    localparam logic [3:0] S_TMUL  = 4'd9;
    localparam logic [3:0] S_TWR   = 4'd10;
    localparam logic [3:0] S_TEND  = 4'd11;
    localparam logic [3:0] S_RLOAD = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    // Control state.
    logic [3:0]        r_state, n_state;
    logic [PPU_AW-1:0] r_idx, n_idx;
    logic [PPU_AW:0]   r_lowest, n_lowest;
    logic [PPU_AW-1:0] r_highest, n_highest;
    logic [PPU_CW-1:0] r_live, n_live;
    logic [PPU_AW-1:0] r_top, n_top;
    logic [3:0]        r_step, n_step;
    logic              r_ovalid, n_ovalid;

    // Item and working values.
    t_in_data          r_in, n_in;
    logic [31:0]       r_rot_a, n_rot_a;
    logic [31:0]       r_rot_b, n_rot_b;
    logic [16:0]       r_q, n_q;
    logic [31:0]       r_nx, n_nx;
    logic [31:0]       r_ny, n_ny;
    logic [31:0]       r_rot, n_rot;
    logic [15:0]       r_scale, n_scale;
    logic [31:0]       r_color, n_color;

    // Result fields and output register.
    logic              r_res_acc, n_res_acc;
    logic [9:0]        r_res_slot, n_res_slot;
    logic [31:0]       r_res_x, n_res_x;
    logic [31:0]       r_res_y, n_res_y;
    logic [31:0]       r_res_color, n_res_color;
    logic [15:0]       r_res_scale, n_res_scale;
    logic [31:0]       r_res_rot, n_res_rot;
    logic [31:0]       r_res_rem, n_res_rem;
    t_out_data         r_out_data, n_out_data;
    logic              r_out_acc, n_out_acc;

    // Memory ports.
    logic              c_rd_en;
    logic [PPU_AW-1:0] c_rd_addr;
    logic              c_wr_en;
    logic              c_rwr_en;
    logic [PPU_AW-1:0] c_wr_addr;
    t_part             c_wr_data;
    t_render           c_rwr_data;
    t_part             c_prd;
    t_render           c_rrd;

    // Arithmetic.
    t_in_data          c_in;
    t_div_req          c_div_req;
    t_div_rsp          c_div_rsp;
    t_mul_req          c_mul_req;
    logic signed [64:0] c_prod;
    logic signed [64:0] c_round;
    logic [31:0]       c_rad;
    logic [31:0]       c_mstep;
    logic [31:0]       c_pos_sel;
    logic [32:0]       c_sum;
    logic [31:0]       c_sat;
    logic [31:0]       c_rem_new;
    logic [1:0]        c_byte_op;
    logic [1:0]        c_byte_use;

    assign c_in = t_in_data'(s_axis_tdata);

    // Particle and render memories.
    ppu_ram #(.WIDTH($bits(t_part)), .DEPTH(PPU_DEPTH)) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (c_wr_en),
        .i_waddr (c_wr_addr),
        .i_wdata (c_wr_data),
        .i_re    (c_rd_en),
        .i_raddr (c_rd_addr),
        .o_rdata (c_prd)
    );

    ppu_ram #(.WIDTH($bits(t_render)), .DEPTH(PPU_DEPTH)) u_rend_ram (
        .i_clk   (i_clk),
        .i_we    (c_rwr_en),
        .i_waddr (c_wr_addr),
        .i_wdata (c_rwr_data),
        .i_re    (c_rd_en),
        .i_raddr (c_rd_addr),
        .o_rdata (c_rrd)
    );

    // Blend factor divider and shared multiplier.
    ppu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_div_req),
        .o_rsp   (c_div_rsp)
    );

    ppu_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (c_mul_req),
        .o_prod (c_prod)
    );

    // Product post-processing: degree rounding, motion step and saturation.
    always_comb begin
        c_round    = c_prod + PPU_HALF32;
        c_rad      = c_round[63:32];
        c_mstep    = c_prod[47:16];
        if (r_step == MS_VX + 4'd1) begin
            c_pos_sel = c_prd.pos_x;
        end else begin
            c_pos_sel = c_prd.pos_y;
        end
        c_sum      = {c_pos_sel[31], c_pos_sel} + {c_mstep[31], c_mstep};
        if (c_sum[32] != c_sum[31]) begin
            c_sat = c_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            c_sat = c_sum[31:0];
        end
        c_rem_new  = c_prd.remaining - {1'b0, r_in.delta_time};
        c_byte_op  = 2'(r_step - MS_COL0);
        c_byte_use = 2'(r_step - MS_COL0 - 4'd1);
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_lowest    = r_lowest;
        n_highest   = r_highest;
        n_live      = r_live;
        n_top       = r_top;
        n_step      = r_step;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_in        = r_in;
        n_rot_a     = r_rot_a;
        n_rot_b     = r_rot_b;
        n_q         = r_q;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_rot       = r_rot;
        n_scale     = r_scale;
        n_color     = r_color;
        n_res_acc   = r_res_acc;
        n_res_slot  = r_res_slot;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_res_color = r_res_color;
        n_res_scale = r_res_scale;
        n_res_rot   = r_res_rot;
        n_res_rem   = r_res_rem;
        n_out_data  = r_out_data;
        n_out_acc   = r_out_acc;
        c_rd_en     = 1'b0;
        c_rd_addr   = r_idx;
        c_wr_en     = 1'b0;
        c_rwr_en    = 1'b0;
        c_wr_addr   = r_idx;
        c_wr_data   = c_prd;
        c_rwr_data  = '{color: r_color, scale: r_scale, rot: r_rot};
        c_div_req   = '0;
        c_mul_req   = '0;

        case (r_state)
            // Clear both memories after reset, one slot a cycle.
            S_CLR: begin
                c_wr_en    = 1'b1;
                c_rwr_en   = 1'b1;
                c_wr_data  = '0;
                c_rwr_data = '0;
                if (r_idx == PPU_LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Take an item and start its work.
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_in        = c_in;
                    n_rot_a     = c_in.rotation_pair[63:32];
                    n_rot_b     = c_in.rotation_pair[31:0];
                    n_res_acc   = 1'b1;
                    n_res_slot  = '0;
                    n_res_x     = '0;
                    n_res_y     = '0;
                    n_res_color = '0;
                    n_res_scale = '0;
                    n_res_rot   = '0;
                    n_res_rem   = '0;
                    case (s_axis_tuser)
                        OP_EMIT_RAD, OP_EMIT_DEG: begin
                            if (r_lowest == PPU_FULL) begin
                                n_res_acc = 1'b0;
                                n_state   = S_OUT;
                            end else begin
                                n_idx   = r_lowest[PPU_AW-1:0];
                                n_state = (s_axis_tuser == OP_EMIT_DEG) ? S_EDEG0 : S_EWR;
                            end
                        end
                        OP_TICK: begin
                            n_idx     = '0;
                            n_top     = '0;
                            c_rd_en   = 1'b1;
                            c_rd_addr = '0;
                            n_state   = S_TLOAD;
                        end
                        OP_READ: begin
                            n_res_slot = c_in.slot;
                            c_rd_en    = 1'b1;
                            c_rd_addr  = PPU_AW'(c_in.slot);
                            n_state    = S_RLOAD;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            // Degrees to radians for both rotation ends.
            S_EDEG0: begin
                c_mul_req.a = {r_rot_a[31], r_rot_a};
                c_mul_req.b = PPU_DEG_K;
                n_state     = S_EDEG1;
            end
            S_EDEG1: begin
                c_mul_req.a = {r_rot_b[31], r_rot_b};
                c_mul_req.b = PPU_DEG_K;
                n_rot_a     = c_rad;
                n_state     = S_EDEG2;
            end
            S_EDEG2: begin
                n_rot_b = c_rad;
                n_state = S_EWR;
            end

            // Store the new particle and start the search for the next free slot.
            S_EWR: begin
                c_wr_en   = 1'b1;
                c_wr_data = '{remaining:  {1'b0, r_in.lifetime},
                              total:      {1'b0, r_in.lifetime},
                              pos_x:      r_in.pos_x,
                              pos_y:      r_in.pos_y,
                              vel_x:      r_in.vel_x,
                              vel_y:      r_in.vel_y,
                              color_a:    r_in.start_color,
                              color_b:    r_in.end_color,
                              scale_pair: r_in.scale_pair,
                              rot_a:      r_rot_a,
                              rot_b:      r_rot_b};
                if (r_in.lifetime != '0) begin
                    n_live = r_live + 1'b1;
                end
                if (r_idx > r_highest) begin
                    n_highest = r_idx;
                end
                n_res_acc  = 1'b1;
                n_res_slot = 10'(r_idx);
                if (r_idx == PPU_LAST) begin
                    n_lowest = PPU_FULL;
                    n_state  = S_OUT;
                end else begin
                    c_rd_en   = 1'b1;
                    c_rd_addr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_state   = S_ESCAN;
                end
            end

            // Walk upwards until a slot with no lifetime left.
            S_ESCAN: begin
                if ($signed(c_prd.remaining) <= 0) begin
                    n_lowest = {1'b0, r_idx};
                    n_state  = S_OUT;
                end else if (r_idx == PPU_LAST) begin
                    n_lowest = PPU_FULL;
                    n_state  = S_OUT;
                end else begin
                    c_rd_en   = 1'b1;
                    c_rd_addr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                end
            end

            // Tick: look at one slot and pick the blend factor.
            S_TLOAD: begin
                if ($signed(c_prd.remaining) <= 0) begin
                    if (r_idx == r_highest) begin
                        n_state = S_TEND;
                    end else begin
                        c_rd_en   = 1'b1;
                        c_rd_addr = r_idx + 1'b1;
                        n_idx     = r_idx + 1'b1;
                    end
                end else if (c_prd.total != '0 && c_prd.remaining < c_prd.total) begin
                    c_div_req.start = 1'b1;
                    c_div_req.num   = c_prd.remaining;
                    c_div_req.den   = c_prd.total;
                    n_state         = S_TDIV;
                end else begin
                    n_q     = PPU_Q_ONE;
                    n_step  = MS_VX;
                    n_state = S_TMUL;
                end
            end

            S_TDIV: begin
                if (c_div_rsp.done) begin
                    n_q     = {1'b0, c_div_rsp.quo};
                    n_step  = MS_VX;
                    n_state = S_TMUL;
                end
            end

            // Motion and blends through the shared multiplier, one product a cycle.
            S_TMUL: begin
                case (r_step)
                    MS_VX: begin
                        c_mul_req.a = {c_prd.vel_x[31], c_prd.vel_x};
                        c_mul_req.b = {1'b0, r_in.delta_time};
                    end
                    MS_VY: begin
                        c_mul_req.a = {c_prd.vel_y[31], c_prd.vel_y};
                        c_mul_req.b = {1'b0, r_in.delta_time};
                    end
                    MS_ROT: begin
                        c_mul_req.a = {c_prd.rot_a[31], c_prd.rot_a}
                                    - {c_prd.rot_b[31], c_prd.rot_b};
                        c_mul_req.b = {15'b0, r_q};
                    end
                    MS_SCALE: begin
                        c_mul_req.a = {17'b0, c_prd.scale_pair[31:16]}
                                    - {17'b0, c_prd.scale_pair[15:0]};
                        c_mul_req.b = {15'b0, r_q};
                    end
                    default: begin
                        if (r_step inside {[MS_COL0:MS_COL3]}) begin
                            c_mul_req.a = {25'b0, c_prd.color_a[8*c_byte_op +: 8]}
                                        - {25'b0, c_prd.color_b[8*c_byte_op +: 8]};
                            c_mul_req.b = {15'b0, r_q};
                        end
                    end
                endcase

                // Take the product issued in the previous cycle.
                case (r_step)
                    MS_VX + 4'd1: begin
                        n_nx = c_sat;
                    end
                    MS_VY + 4'd1: begin
                        n_ny = c_sat;
                    end
                    MS_ROT + 4'd1: begin
                        n_rot = c_prd.rot_b + c_prod[47:16];
                    end
                    MS_SCALE + 4'd1: begin
                        n_scale = c_prd.scale_pair[15:0] + c_prod[31:16];
                    end
                    default: begin
                        if (r_step inside {[MS_COL0 + 4'd1:MS_DONE]}) begin
                            n_color[8*c_byte_use +: 8] =
                                c_prd.color_b[8*c_byte_use +: 8] + c_prod[23:16];
                        end
                    end
                endcase

                n_step = r_step + 1'b1;
                if (r_step == MS_DONE) begin
                    n_state = S_TWR;
                end
            end

            // Write back the slot and keep the free and live bookkeeping.
            S_TWR: begin
                c_wr_en   = 1'b1;
                c_rwr_en  = 1'b1;
                c_wr_data = c_prd;
                c_wr_data.remaining = c_rem_new;
                c_wr_data.pos_x     = r_nx;
                c_wr_data.pos_y     = r_ny;
                if ($signed(c_rem_new) <= 0) begin
                    n_live = r_live - 1'b1;
                    if ({1'b0, r_idx} < r_lowest) begin
                        n_lowest = {1'b0, r_idx};
                    end
                end else begin
                    n_top = r_idx;
                end
                if (r_idx == r_highest) begin
                    n_state = S_TEND;
                end else begin
                    c_rd_en   = 1'b1;
                    c_rd_addr = r_idx + 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_state   = S_TLOAD;
                end
            end

            // The highest slot in use becomes the highest live one.
            S_TEND: begin
                n_highest = r_top;
                n_state   = S_OUT;
            end

            // Read one slot's render values.
            S_RLOAD: begin
                if (32'(r_in.slot) < 32'(PPU_DEPTH)) begin
                    n_res_acc   = 1'b1;
                    n_res_x     = c_prd.pos_x;
                    n_res_y     = c_prd.pos_y;
                    n_res_color = c_rrd.color;
                    n_res_scale = c_rrd.scale;
                    n_res_rot   = c_rrd.rot;
                    n_res_rem   = c_prd.remaining;
                end else begin
                    n_res_acc = 1'b0;
                end
                n_state = S_OUT;
            end

            // Hand the result to the output register once it is free.
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_out_acc  = r_res_acc;
                    n_out_data = '{pad:           1'b0,
                                   highest_used:  10'(r_highest),
                                   live_count:    11'(r_live),
                                   out_remaining: r_res_rem,
                                   out_rotation:  r_res_rot,
                                   out_scale:     r_res_scale,
                                   out_color:     r_res_color,
                                   out_y:         r_res_y,
                                   out_x:         r_res_x,
                                   slot_used:     r_res_slot};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_lowest  <= '0;
            r_highest <= '0;
            r_live    <= '0;
            r_top     <= '0;
            r_step    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_lowest  <= n_lowest;
            r_highest <= n_highest;
            r_live    <= n_live;
            r_top     <= n_top;
            r_step    <= n_step;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in        <= n_in;
        r_rot_a     <= n_rot_a;
        r_rot_b     <= n_rot_b;
        r_q         <= n_q;
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_rot       <= n_rot;
        r_scale     <= n_scale;
        r_color     <= n_color;
        r_res_acc   <= n_res_acc;
        r_res_slot  <= n_res_slot;
        r_res_x     <= n_res_x;
        r_res_y     <= n_res_y;
        r_res_color <= n_res_color;
        r_res_scale <= n_res_scale;
        r_res_rot   <= n_res_rot;
        r_res_rem   <= n_res_rem;
        r_out_data  <= n_out_data;
        r_out_acc   <= n_out_acc;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_acc;

endmodule

[src/ppu_chk.sv]
// Port-level checker for the particle pool update block, bound to the top level.
// Depends on ppu_pkg and particle_pool_update_assert.svh.
`include "particle_pool_update_assert.svh"

module ppu_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ppu_pkg::PPU_OUT_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);
    import ppu_pkg::*;

    t_out_data c_res;

    assign c_res = t_out_data'(m_axis_tdata);

    // A waiting result stays offered and unchanged.
    `PPU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `PPU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // The live count never exceeds the pool, nor the slots up to the highest in use.
    `PPU_ASSERT_NOW(a_live_max, m_axis_tvalid, c_res.live_count <= 11'(PPU_DEPTH),
        "live count beyond pool size")
    `PPU_ASSERT_NOW(a_live_high, m_axis_tvalid,
        {1'b0, c_res.live_count} <= ({2'b0, c_res.highest_used} + 12'd1),
        "live slot above highest used slot")

endmodule

bind particle_pool_update ppu_chk u_ppu_chk (.*);

[dv/tb.sv]
// Self-checking testbench of the particle pool update block.
// Depends on ppu_pkg and particle_pool_update; predicts every result item in a scoreboard class.
`timescale 1ns / 1ps

module tb;
    import ppu_pkg::*;

    localparam int  POOL       = 1024;
    localparam int  CYCLE_CAP  = 4000000;
    localparam int  RAND_ITEMS = 560;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // pos_x, pos_y, vel_x, vel_y, start_color, end_color, scale_pair,
    // rotation_pair, lifetime, delta_time, slot
    logic [PPU_IN_W-1:0]   s_axis_tdata;
    // opcode
    logic [PPU_OP_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // slot_used, out_x, out_y, out_color, out_scale, out_rotation,
    // out_remaining, live_count, highest_used
    logic [PPU_OUT_W-1:0]  m_axis_tdata;
    // accepted
    logic                  m_axis_tuser;

    typedef struct {
        logic      accepted;
        t_out_data fields;
    } t_pool_result;

    particle_pool_update dut (.*);

    // Shadow copy of the pool, and the results it predicts in arrival order.
    class pool_scoreboard;
        logic [31:0] remaining [POOL];
        logic [31:0] total [POOL];
        logic [31:0] pos_x [POOL];
        logic [31:0] pos_y [POOL];
        logic [31:0] vel_x [POOL];
        logic [31:0] vel_y [POOL];
        logic [31:0] color_a [POOL];
        logic [31:0] color_b [POOL];
        logic [31:0] scale_ends [POOL];
        logic [31:0] rot_a [POOL];
        logic [31:0] rot_b [POOL];
        t_render     shown [POOL];
        int          lowest_free;
        int          highest;
        t_pool_result pending [$];
        int          mismatches;

        function new();
            for (int i = 0; i < POOL; i++) begin
                remaining[i] = '0;
                pos_x[i]     = '0;
                pos_y[i]     = '0;
                shown[i]     = '0;
            end
            lowest_free = 0;
            highest     = 0;
            mismatches  = 0;
        endfunction

        function longint blend(longint a, longint b, longint q);
            return (a * q + b * (65536 - q)) >>> 16;
        endfunction

        function logic [31:0] blend_signed(logic [31:0] a, logic [31:0] b, longint q);
            longint ua;
            longint ub;
            ua = longint'($signed(a)) + 64'sd2147483648;
            ub = longint'($signed(b)) + 64'sd2147483648;
            return 32'(blend(ua, ub, q) - 64'sd2147483648);
        endfunction

        // Degrees to radians, pi/180 in Q0.32, rounded half up.
        function logic [31:0] to_radians(logic [31:0] d);
            longint p;
            p = longint'($signed(d)) * 64'sd74961321 + 64'sd2147483648;
            return 32'(p >>> 32);
        endfunction

        // Position advanced by velocity times delta, saturated; the step
        // itself wraps to 32 bits before it is added.
        function logic [31:0] advance(logic [31:0] p, logic [31:0] v, logic [30:0] dt);
            longint st;
            longint s;
            st = (longint'($signed(v)) * longint'({1'b0, dt})) >>> 16;
            s  = longint'($signed(p)) + longint'($signed(st[31:0]));
            if (s > 64'sd2147483647) return 32'h7fffffff;
            if (s < -64'sd2147483648) return 32'h80000000;
            return 32'(s);
        endfunction

        function int live_slots();
            int n;
            n = 0;
            for (int i = 0; i <= highest; i++)
                if ($signed(remaining[i]) > 0) n++;
            return n;
        endfunction

        function void do_emit(logic [1:0] op, t_in_data d, ref t_pool_result r);
            int idx;
            idx = lowest_free;
            lowest_free = POOL;
            for (int i = idx + 1; i < POOL; i++)
                if ($signed(remaining[i]) <= 0) begin
                    lowest_free = i;
                    break;
                end
            if (idx >= POOL) return;
            if (idx > highest) highest = idx;
            pos_x[idx]      = d.pos_x;
            pos_y[idx]      = d.pos_y;
            vel_x[idx]      = d.vel_x;
            vel_y[idx]      = d.vel_y;
            color_a[idx]    = d.start_color;
            color_b[idx]    = d.end_color;
            scale_ends[idx] = d.scale_pair;
            rot_a[idx]      = d.rotation_pair[63:32];
            rot_b[idx]      = d.rotation_pair[31:0];
            if (op == OP_EMIT_DEG) begin
                rot_a[idx] = to_radians(rot_a[idx]);
                rot_b[idx] = to_radians(rot_b[idx]);
            end
            total[idx]     = {1'b0, d.lifetime};
            remaining[idx] = {1'b0, d.lifetime};
            r.accepted = 1'b1;
            r.fields.slot_used = idx[9:0];
        endfunction

        function void do_tick(logic [30:0] dt);
            longint q;
            longint rem;
            logic [31:0] c;
            for (int i = 0; i <= highest; i++) begin
                if ($signed(remaining[i]) <= 0) continue;
                q = 65536;
                if (total[i] != 0 && remaining[i] <= total[i])
                    q = (longint'(remaining[i]) << 16) / longint'(total[i]);
                pos_x[i] = advance(pos_x[i], vel_x[i], dt);
                pos_y[i] = advance(pos_y[i], vel_y[i], dt);
                for (int k = 0; k < 32; k += 8)
                    c[k +: 8] = 8'(blend(longint'(color_a[i][k +: 8]),
                                         longint'(color_b[i][k +: 8]), q));
                shown[i].color = c;
                shown[i].scale = 16'(blend(longint'(scale_ends[i][31:16]),
                                           longint'(scale_ends[i][15:0]), q));
                shown[i].rot   = blend_signed(rot_a[i], rot_b[i], q);
                rem = longint'($signed(remaining[i])) - longint'(dt);
                remaining[i] = 32'(rem);
                if (rem <= 0 && i < lowest_free) lowest_free = i;
            end
            while (highest > 0 && $signed(remaining[highest]) <= 0) highest--;
        endfunction

        // An item was taken by the block: work out the result it must give.
        function void note_item(logic [1:0] op, t_in_data d);
            t_pool_result r;
            r.accepted = 1'b0;
            r.fields   = '0;
            case (op)
                OP_EMIT_RAD, OP_EMIT_DEG: begin
                    do_emit(op, d, r);
                end
                OP_TICK: begin
                    do_tick(d.delta_time);
                    r.accepted = 1'b1;
                end
                default: begin
                    r.accepted             = 1'b1;
                    r.fields.slot_used     = d.slot;
                    r.fields.out_x         = pos_x[d.slot];
                    r.fields.out_y         = pos_y[d.slot];
                    r.fields.out_color     = shown[d.slot].color;
                    r.fields.out_scale     = shown[d.slot].scale;
                    r.fields.out_rotation  = shown[d.slot].rot;
                    r.fields.out_remaining = remaining[d.slot];
                end
            endcase
            r.fields.live_count   = 11'(live_slots());
            r.fields.highest_used = 10'(highest);
            pending.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %s: expected %h, got %h", name, want, got);
            end
        endfunction

        // A result came out of the block: it must match the oldest prediction.
        function void check_result(logic acc, t_out_data got);
            t_pool_result w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("MISMATCH: result item with none expected");
                return;
            end
            w = pending.pop_front();
            compare("accepted", w.accepted, acc);
            compare("slot_used", w.fields.slot_used, got.slot_used);
            compare("out_x", w.fields.out_x, got.out_x);
            compare("out_y", w.fields.out_y, got.out_y);
            compare("out_color", w.fields.out_color, got.out_color);
            compare("out_scale", w.fields.out_scale, got.out_scale);
            compare("out_rotation", w.fields.out_rotation, got.out_rotation);
            compare("out_remaining", w.fields.out_remaining, got.out_remaining);
            compare("live_count", w.fields.live_count, got.live_count);
            compare("highest_used", w.fields.highest_used, got.highest_used);
        endfunction
    endclass

    pool_scoreboard pool_sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycle_count;

    // Clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("particle_pool_update regression: fail");
            $finish;
        end
    end

    // Receiver with random stalls.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watch both channels; values read here are those before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pool_sb.note_item(s_axis_tuser, t_in_data'(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pool_sb.check_result(m_axis_tuser, t_out_data'(m_axis_tdata));
    end

    // Offer one item and return at the edge where it is taken.
    task automatic send_item(logic [1:0] op, t_in_data d);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Hold off the sender until every predicted result has been seen.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pool_sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_data random_fields();
        t_in_data d;
        d.pos_x         = $urandom;
        d.pos_y         = $urandom;
        d.vel_x         = $urandom;
        d.vel_y         = $urandom;
        d.start_color   = $urandom;
        d.end_color     = $urandom;
        d.scale_pair    = $urandom;
        d.rotation_pair = {$urandom, $urandom};
        d.lifetime      = 31'($urandom_range(0, 32'h60000));
        d.delta_time    = 31'($urandom_range(0, 32'h20000));
        d.slot          = 10'($urandom);
        return d;
    endfunction

    task automatic send_tick(logic [30:0] dt);
        t_in_data d;
        d = random_fields();
        d.delta_time = dt;
        send_item(OP_TICK, d);
    endtask

    task automatic send_read(int s);
        t_in_data d;
        d = random_fields();
        d.slot = 10'(s);
        send_item(OP_READ, d);
    endtask

    initial begin
        t_in_data d;
        int       pick;
        pool_sb        = new();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = OP_READ;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes, both emit kinds, saturation, zero life.
        send_read(0);
        d = random_fields();
        d.pos_x = 32'h7fffffff; d.pos_y = 32'h80000000;
        d.vel_x = 32'h7fffffff; d.vel_y = 32'h80000000;
        d.start_color = 32'hffffffff; d.end_color = 32'h0;
        d.scale_pair = 32'hffff0000; d.rotation_pair = 64'h7fffffff_80000000;
        d.lifetime = 31'h7fffffff;
        send_item(OP_EMIT_RAD, d);
        d = random_fields();
        d.rotation_pair = 64'h80000000_7fffffff;
        d.start_color = 32'h0; d.end_color = 32'hffffffff; d.scale_pair = 32'h0000ffff;
        d.lifetime = 31'h10000;
        send_item(OP_EMIT_DEG, d);
        d = random_fields();
        d.lifetime = '0;
        send_item(OP_EMIT_RAD, d);
        d = random_fields();
        d.pos_x = 32'h80000000; d.pos_y = 32'h7fffffff;
        d.vel_x = 32'h80000000; d.vel_y = 32'h7fffffff;
        d.rotation_pair = 64'h00b40000_ff4c0000;
        send_item(OP_EMIT_DEG, d);
        send_tick(31'h8000);
        send_tick('0);
        for (int s = 0; s < 4; s++) send_read(s);
        send_tick(31'h7fffffff);
        for (int s = 0; s < 3; s++) send_read(s);
        send_read(POOL - 1);
        drain();

        // Random part in four idling phases, each closed by a full drain.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < RAND_ITEMS / 4; n++) begin
                pick = $urandom_range(99);
                d = random_fields();
                if (pick < 38) begin
                    if ($urandom_range(15) == 0) d.lifetime = 31'($urandom);
                    send_item($urandom_range(1) ? OP_EMIT_DEG : OP_EMIT_RAD, d);
                end else if (pick < 62) begin
                    send_item(OP_TICK, d);
                end else begin
                    if ($urandom_range(3) != 0)
                        d.slot = 10'($urandom_range(0, pool_sb.highest + 2));
                    send_item(OP_READ, d);
                end
            end
            drain();
        end

        // Let every particle expire, then read back.
        send_idle_pct  = 0;
        recv_stall_pct = 10;
        send_tick(31'h7fffffff);
        send_read(0);
        send_read(POOL - 1);
        drain();

        repeat (60) @(posedge i_clk);
        if (pool_sb.mismatches == 0 && pool_sb.pending.size() == 0) begin
            $display("particle_pool_update regression: pass");
        end else begin
            $display("particle_pool_update regression: fail");
        end
        $finish;
    end

endmodule
